// ===== hdl/cdfs_pkg.sv =====
`timescale 1ns / 1ps
// cdfs_pkg: shared constants of the cdf table inverse sampler
// no dependencies; imported by the interfaces, the divider, the top level, the checker and the bench
package cdfs_pkg;

	localparam int INDEX_W = 10;
	localparam int ANGLE_W = 17;
	localparam int FRAC_W  = 16;

	localparam logic [ANGLE_W-1:0] ANGLE_ONE = 17'h10000;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

endpackage

// ===== hdl/cdfs_if.sv =====
`timescale 1ns / 1ps
// cdfs_in_if / cdfs_out_if: valid-ready channels of the sampler
// depends on cdfs_pkg for the fixed field widths
interface cdfs_in_if import cdfs_pkg::*; #(
	parameter int ENTRY_W  = 25,
	parameter int RANDOM_W = 24
) ();
	logic                valid;
	logic                ready;
	logic                operation;
	logic [INDEX_W-1:0]  entry_index;
	logic [ENTRY_W-1:0]  entry_value;
	logic [RANDOM_W-1:0] random_value;

	modport source (output valid, operation, entry_index, entry_value, random_value,
		input ready);
	modport sink (input valid, operation, entry_index, entry_value, random_value,
		output ready);
endinterface

interface cdfs_out_if import cdfs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] angle_over_pi;

	modport source (output valid, angle_over_pi, input ready);
	modport sink (input valid, angle_over_pi, output ready);
endinterface

// ===== hdl/cdfs_ram.sv =====
`timescale 1ns / 1ps
// cdfs_ram: generic single-write, single-read ram with registered read data
// no dependencies
module cdfs_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/cdfs_div.sv =====
`timescale 1ns / 1ps
// cdfs_div: restoring divider, one quotient bit per cycle, ANGLE_W quotient bits
// depends on cdfs_pkg; caller guarantees numer < denom * 2**ANGLE_W
module cdfs_div import cdfs_pkg::*; #(
	parameter int DEN_W = 25
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DEN_W+ANGLE_W-1:0] numer,
	input  logic [DEN_W-1:0]         denom,
	output logic                     done,
	output logic [ANGLE_W-1:0]       quotient
);

	localparam int NUM_W = DEN_W + ANGLE_W;
	localparam int CNT_W = $clog2(ANGLE_W);

	logic [DEN_W-1:0]   rem_q;
	logic [ANGLE_W-1:0] quo_q;
	logic [DEN_W-1:0]   den_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DEN_W:0]     trial;
	logic [DEN_W:0]     trial_sub;
	logic               fits;

	assign trial     = {rem_q, quo_q[ANGLE_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign fits      = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(ANGLE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where the numerator bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer[NUM_W-1:ANGLE_W];
			quo_q <= numer[ANGLE_W-1:0];
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[ANGLE_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/cdf_table_inverse_sampler.sv =====
`timescale 1ns / 1ps
// cdf_table_inverse_sampler: top level, table memory, search and interpolation sequencer
// depends on cdfs_pkg, cdfs_if, cdfs_ram and cdfs_div

// A load transaction writes one cumulative entry into the table, and the next transaction
// is taken at once; an entry_index of TABLE_DEPTH or more is dropped. A sample transaction
// binary-searches the table with one memory read per cycle and then reads the two
// bracketing entries. It then runs the bit-serial divider for the segment fraction, 17
// quotient bits, and hands the quotient over. The scaling by 1/TABLE_DEPTH is a constant
// reciprocal multiply registered in S_SCALE, and the output register is loaded from
// S_RESULT in the same cycle as the input turns ready again. A zero-width segment, or a
// draw at or outside the segment ends, skips the divider. A search that runs past the
// last entry goes from the search straight to S_RESULT with pi. Only one sample is in
// flight. Loads and new samples are taken while a finished result still waits in the
// output register; a second finished result holds the sampler, and so the input, until
// the first one leaves. Entries must be loaded before a sample reads them: the table has
// no reset.
module cdf_table_inverse_sampler import cdfs_pkg::*; #(
	parameter int TABLE_DEPTH    = 1024,
	parameter int PROB_FRAC_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	cdfs_in_if.sink    items,
	cdfs_out_if.source results
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CW    = $clog2(TABLE_DEPTH + 1);
	localparam int EW    = PROB_FRAC_BITS + 1;
	localparam int NUM_W = EW + ANGLE_W;
	// (i-1)*65536 + f never exceeds TABLE_DEPTH*65536, below 2**SW
	localparam int SW    = CW + FRAC_W;
	localparam int RSH   = SW + AW;
	localparam int RW    = SW + 1;
	localparam longint unsigned RECIP_L =
		((64'd1 << RSH) + 64'(TABLE_DEPTH - 1)) / 64'(TABLE_DEPTH);
	localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_LOWER  = 3'd2;
	localparam logic [2:0] S_UPPER  = 3'd3;
	localparam logic [2:0] S_DIVF   = 3'd4;
	localparam logic [2:0] S_SCALE  = 3'd5;
	localparam logic [2:0] S_RESULT = 3'd6;

	logic [2:0]                state_q;
	logic                      out_valid_q;
	logic [ANGLE_W-1:0]        out_q;
	logic [PROB_FRAC_BITS-1:0] r_q;
	logic [CW-1:0]             lo_q;
	logic [CW-1:0]             hi_q;
	logic [CW-1:0]             mid_q;
	logic [CW-1:0]             idx_q;
	logic [EW-1:0]             lower_q;
	logic [ANGLE_W-1:0]        f_q;
	logic [ANGLE_W-1:0]        angle_q;

	logic                      accept;
	logic                      out_free;
	logic                      ram_we;
	logic [AW-1:0]             ram_raddr;
	logic [EW-1:0]             rdata;
	logic [EW-1:0]             r_ext;
	logic                      below;
	logic [CW-1:0]             lo_n;
	logic [CW-1:0]             hi_n;
	logic [CW:0]               mid_sum;
	logic [CW-1:0]             mid_n;
	logic                      search_done;
	logic                      hit_end;
	logic [CW-1:0]             ic;
	logic                      flat;
	logic                      at_top;
	logic [EW-1:0]             r_minus_lower;
	logic [EW-1:0]             seg_width;
	logic [NUM_W-1:0]          num_frac;
	logic [SW-1:0]             scale_num;
	logic [SW+RW-1:0]          scale_prod;
	logic                      div_start;
	logic                      div_done;
	logic [ANGLE_W-1:0]        div_quo;

	assign accept   = items.valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || results.ready;
	assign ram_we   = accept && (items.operation == OP_LOAD)
		&& (32'(items.entry_index) < 32'(TABLE_DEPTH));

	// search step: next bounds and next probe straight from the read data
	assign r_ext       = EW'(r_q);
	assign below       = rdata < r_ext;
	assign lo_n        = below ? CW'(mid_q + 1'b1) : lo_q;
	assign hi_n        = below ? hi_q : mid_q;
	assign mid_sum     = (CW+1)'(lo_n) + (CW+1)'(hi_n);
	assign mid_n       = mid_sum[CW:1];
	assign search_done = !(lo_n < hi_n);
	assign hit_end     = lo_n == CW'(TABLE_DEPTH);
	assign ic          = (lo_n == '0) ? CW'(1) : lo_n;

	// segment checks, rdata holds the upper entry in S_UPPER
	assign flat          = (rdata <= lower_q) || (r_ext <= lower_q);
	assign at_top        = r_ext >= rdata;
	assign r_minus_lower = r_ext - lower_q;
	assign seg_width     = rdata - lower_q;
	assign num_frac      = NUM_W'(r_minus_lower) << FRAC_W;
	assign div_start     = (state_q == S_UPPER) && !(flat || at_top);

	// divide by TABLE_DEPTH as a multiply by its rounded-up reciprocal, exact for this range
	assign scale_num  = (SW'(idx_q - CW'(1)) << FRAC_W) + SW'(f_q);
	assign scale_prod = (SW+RW)'(scale_num) * (SW+RW)'(RECIP);

	always_comb begin
		case (state_q)
			S_IDLE:   ram_raddr = AW'(TABLE_DEPTH / 2);
			S_SEARCH: ram_raddr = search_done ? AW'(ic - CW'(1)) : AW'(mid_n);
			S_LOWER:  ram_raddr = AW'(idx_q);
			default:  ram_raddr = '0;
		endcase
	end

	cdfs_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(items.entry_index)),
		.wdata (items.entry_value),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	cdfs_div #(
		.DEN_W (EW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (num_frac),
		.denom    (seg_width),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (items.operation == OP_SAMPLE)) begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (search_done) begin
						state_q <= hit_end ? S_RESULT : S_LOWER;
					end
				end
				S_LOWER: begin
					state_q <= S_UPPER;
				end
				S_UPPER: begin
					state_q <= (flat || at_top) ? S_SCALE : S_DIVF;
				end
				S_DIVF: begin
					if (div_done) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_RESULT) && out_free) begin
			out_q <= angle_q;
		end
		case (state_q)
			S_IDLE: begin
				r_q   <= items.random_value;
				lo_q  <= '0;
				hi_q  <= CW'(TABLE_DEPTH);
				mid_q <= CW'(TABLE_DEPTH / 2);
			end
			S_SEARCH: begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
				idx_q <= ic;
				if (search_done && hit_end) begin
					angle_q <= ANGLE_ONE;
				end
			end
			S_LOWER: begin
				lower_q <= rdata;
			end
			S_UPPER: begin
				f_q <= flat ? '0 : ANGLE_ONE;
			end
			S_DIVF: begin
				if (div_done) begin
					f_q <= div_quo;
				end
			end
			S_SCALE: begin
				angle_q <= scale_prod[RSH +: ANGLE_W];
			end
			default: begin
				lower_q <= lower_q;
			end
		endcase
	end

	assign items.ready           = state_q == S_IDLE;
	assign results.valid         = out_valid_q;
	assign results.angle_over_pi = out_q;

endmodule

// ===== hdl/cdfs_check.sv =====
`timescale 1ns / 1ps
// cdfs_check: port-level assertions for cdf_table_inverse_sampler, bound to the top
// depends on cdfs_pkg and on the top level's channel ports
module cdfs_check import cdfs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_operation,
	input logic               out_valid,
	input logic               out_ready,
	input logic [ANGLE_W-1:0] out_angle
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_angle))
		else $error("result dropped or changed while stalled");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_angle <= ANGLE_ONE)
		else $error("angle above pi");

	a_load_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_operation == OP_LOAD) |=> in_ready)
		else $error("load transaction stalled the input");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_operation == OP_SAMPLE) |=> !in_ready && !$rose(out_valid))
		else $error("sample transaction not held as in flight");

endmodule

bind cdf_table_inverse_sampler cdfs_check u_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (items.valid),
	.in_ready     (items.ready),
	.in_operation (items.operation),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.out_angle    (results.angle_over_pi)
);

// ===== test/tb_cdf_table_inverse_sampler.sv =====
`timescale 1ns / 1ps
// tb_cdf_table_inverse_sampler: self-checking bench for the cdf table inverse sampler
// depends on cdfs_pkg, cdfs_if and the sampler; predicts each angle from a shadow of the table
module tb_cdf_table_inverse_sampler import cdfs_pkg::*; ();

	localparam int DEPTH = 1024;
	localparam int ENTRY_W = 25;
	localparam int RANDOM_W = 24;
	localparam int unsigned PROB_ONE = 32'd16777216;
	localparam int CYCLE_LIMIT = 600000;
	localparam int STALL_LEN = 500;
	localparam int TAIL_CYCLES = 150;
	localparam int RANDOM_ITEMS = 90;

	typedef enum {SHAPE_UNIFORM, SHAPE_PLATEAU, SHAPE_SHORT, SHAPE_RAMP, SHAPE_NOISE}
		table_shape_e;
	typedef enum {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

	logic clk;
	logic arst_n;

	cdfs_in_if #(.ENTRY_W(ENTRY_W), .RANDOM_W(RANDOM_W)) items_ch ();
	cdfs_out_if results_ch ();

	cdf_table_inverse_sampler #(
		.TABLE_DEPTH(DEPTH),
		.PROB_FRAC_BITS(24)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch)
	);

	logic [ENTRY_W-1:0] cdf_shadow [DEPTH];
	logic [ANGLE_W-1:0] angle_expected [$];

	int errors = 0;
	int mismatches = 0;
	int loads_done = 0;
	int samples_done = 0;
	int saturated_done = 0;
	int tables_done = 0;
	int burst_left = 0;
	int stall_left = 0;
	bit stall_request = 0;
	int unsigned cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d angles still pending", cycles,
			angle_expected.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// first entry not below r, clamped to 1, then linear interpolation into that segment
	function automatic logic [ANGLE_W-1:0] predict_angle(input logic [RANDOM_W-1:0] r);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		int unsigned pos;
		longint unsigned rv;
		longint unsigned lower;
		longint unsigned upper;
		longint unsigned frac;
		longint unsigned num;
		lo = 0;
		hi = DEPTH;
		rv = r;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (longint'(cdf_shadow[mid]) < rv) lo = mid + 1;
			else hi = mid;
		end
		if (lo >= DEPTH) return ANGLE_ONE;
		pos = (lo < 1) ? 1 : lo;
		lower = cdf_shadow[pos-1];
		upper = cdf_shadow[pos];
		if (upper <= lower || rv <= lower) frac = 0;
		else if (rv >= upper) frac = 65536;
		else frac = ((rv - lower) << FRAC_W) / (upper - lower);
		num = longint'(pos - 1) * 65536 + frac;
		return ANGLE_W'(num / DEPTH);
	endfunction

	// update the shadow table or queue the predicted angle for one accepted transaction
	function automatic void absorb_item(input logic op, input logic [INDEX_W-1:0] idx,
		input logic [ENTRY_W-1:0] val, input logic [RANDOM_W-1:0] r);
		logic [ANGLE_W-1:0] angle;
		if (op == OP_LOAD) begin
			if (idx < DEPTH) cdf_shadow[idx] = val;
			loads_done++;
		end else begin
			angle = predict_angle(r);
			angle_expected.push_back(angle);
			samples_done++;
			if (angle == ANGLE_ONE) saturated_done++;
		end
	endfunction

	task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
		input logic [ENTRY_W-1:0] val, input logic [RANDOM_W-1:0] r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				@(negedge clk);
				items_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		items_ch.valid <= 1'b1;
		items_ch.operation <= op;
		items_ch.entry_index <= idx;
		items_ch.entry_value <= val;
		items_ch.random_value <= r;
		do @(posedge clk); while (!items_ch.ready);
		absorb_item(op, idx, val, r);
	endtask

	task automatic send_load(input int idx, input longint unsigned val);
		send_item(OP_LOAD, INDEX_W'(idx), ENTRY_W'(val), RANDOM_W'($urandom));
	endtask

	task automatic send_sample(input longint unsigned r);
		send_item(OP_SAMPLE, INDEX_W'($urandom), ENTRY_W'($urandom_range(0, PROB_ONE)),
			RANDOM_W'(r));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		items_ch.valid <= 1'b0;
		burst_left = 0;
		while (angle_expected.size() != 0) @(posedge clk);
	endtask

	// every entry is written before any sample so the search never reads an unwritten word
	task automatic fill_table(input table_shape_e shape);
		longint unsigned vals [DEPTH];
		longint unsigned acc;
		longint unsigned cap;
		acc = 0;
		cap = $urandom_range(PROB_ONE / 4, PROB_ONE * 3 / 4);
		for (int k = 0; k < DEPTH; k++) begin
			case (shape)
				SHAPE_UNIFORM: vals[k] = (longint'(k + 1) * PROB_ONE) / DEPTH;
				SHAPE_PLATEAU: begin
					// flat runs give zero-width segments
					if ($urandom_range(0, 2) == 0) acc += $urandom_range(0, 49152);
					if (acc > PROB_ONE) acc = PROB_ONE;
					vals[k] = acc;
				end
				SHAPE_SHORT: begin
					// never reaches 1.0, so high draws run past the last entry
					acc += $urandom_range(0, 32'(2 * cap / DEPTH));
					if (acc > cap) acc = cap;
					vals[k] = acc;
				end
				SHAPE_RAMP: vals[k] = (longint'(k + 1) * (k + 1) * PROB_ONE) / (DEPTH * DEPTH);
				default: vals[k] = $urandom_range(0, PROB_ONE);
			endcase
		end
		if (shape == SHAPE_PLATEAU) vals[DEPTH-1] = PROB_ONE;
		for (int k = 0; k < DEPTH; k++) send_load(k, vals[k]);
		tables_done++;
	endtask

	function automatic longint unsigned pick_draw();
		int sel;
		longint unsigned v;
		sel = $urandom_range(0, 99);
		v = cdf_shadow[$urandom_range(0, DEPTH - 1)];
		if (sel < 30) begin
			v = v;
		end else if (sel < 45) begin
			if ($urandom_range(0, 1) == 0) v = v + 1;
			else v = (v == 0) ? 0 : v - 1;
		end else if (sel < 52) begin
			v = ($urandom_range(0, 1) == 0) ? 0 : 64'hFFFFFF;
		end else begin
			v = $urandom & 32'hFFFFFF;
		end
		return (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
	endfunction

	function automatic longint unsigned pick_entry();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return 0;
		if (sel == 1) return PROB_ONE;
		return $urandom_range(0, PROB_ONE);
	endfunction

	task automatic test_directed_cases();
		fill_table(SHAPE_UNIFORM);
		send_sample(0);
		send_sample(64'hFFFFFF);
		send_sample(cdf_shadow[0]);
		send_sample(cdf_shadow[511]);
		send_sample(cdf_shadow[511] + 1);
		send_sample(cdf_shadow[511] - 1);
		send_sample(64'h800000);
		// first two entries equal: the zero draw lands on index 0 and that segment has no width
		send_load(0, 0);
		send_load(1, 0);
		send_sample(0);
		send_sample(1);
		// last entry short of 1.0: the top draw finds no entry and saturates
		send_load(DEPTH - 1, 64'hFFFF00);
		send_sample(64'hFFFFFF);
		send_sample(64'hFFFF00);
		send_load(DEPTH - 1, PROB_ONE);
		// first entry at full scale breaks monotonicity
		send_load(0, PROB_ONE);
		send_sample(1);
		send_sample(64'h000100);
		send_load(0, 16384);
		send_load(1, 32768);
		send_sample(64'h004000);
		send_sample(64'h00A000);
		wait_drained();
	endtask

	task automatic test_backpressure();
		stall_request = 1'b1;
		burst_left = 64;
		repeat (16) send_sample(pick_draw());
		wait_drained();
	endtask

	// random rewrites of single entries mixed with draws over the loaded table
	task automatic test_random_tables();
		repeat (RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 85) send_sample(pick_draw());
			else send_load($urandom_range(0, DEPTH - 1), pick_entry());
		end
		wait_drained();
	endtask

	// receiver: a changing ready pattern, plus one long hold-off on request
	initial begin
		rx_mode_e mode;
		int mode_left;
		int unsigned tick;
		mode = RX_ALWAYS;
		mode_left = 0;
		tick = 0;
		results_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			tick++;
			if (stall_request) begin
				stall_left = STALL_LEN;
				stall_request = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				results_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 64);
				end
				mode_left--;
				case (mode)
					RX_ALWAYS: results_ch.ready <= 1'b1;
					RX_MOSTLY: results_ch.ready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: results_ch.ready <= ($urandom_range(0, 9) < 3);
					default: results_ch.ready <= (tick % 4 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		logic [ANGLE_W-1:0] want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (angle_expected.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected angle_over_pi %h at cycle %0d",
						results_ch.angle_over_pi, cycles);
			end else begin
				want = angle_expected.pop_front();
				if (results_ch.angle_over_pi !== want) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("angle_over_pi mismatch at cycle %0d: expected %h, got %h",
							cycles, want, results_ch.angle_over_pi);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		items_ch.valid = 1'b0;
		items_ch.operation = OP_LOAD;
		items_ch.entry_index = '0;
		items_ch.entry_value = '0;
		items_ch.random_value = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_backpressure();
		test_random_tables();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (angle_expected.size() != 0) begin
			errors += angle_expected.size();
			$display("%0d angles never arrived", angle_expected.size());
		end
		$display("ran %0d table loads over %0d full tables and %0d samples, %0d at pi",
			loads_done, tables_done, samples_done, saturated_done);
		$display("%0d mismatches in %0d cycles, including a %0d-cycle result hold-off",
			mismatches, cycles, STALL_LEN);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
